>>> rtl/blm_pkg.sv
package blm_pkg;

  // Samples averaged into one voltage reading.
  localparam int SAMPLES_PER_READ = 16;

  localparam int SAMPLE_W = 12;
  localparam int OFFSET_W = 8;
  localparam int MV_W     = 15;
  localparam int TIMER_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Sum of one full group: each sample at most 4095 + 255.
  localparam int SUM_W = $clog2(SAMPLES_PER_READ * ((2 ** SAMPLE_W - 1) + (2 ** OFFSET_W - 1)) + 1);
  localparam int PROD_W = SUM_W + 4;
  localparam int CNT_W = $clog2(SAMPLES_PER_READ + 1);
  // sum * 11 / (2 * N) gives average times 5.5.
  localparam int AVG_DIV = 2 * SAMPLES_PER_READ;

  localparam logic [MV_W-1:0] VALID_MIN_MV = MV_W'(500);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MID           = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FULL          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN_HOLD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_READ_PERIOD   = 3'd7;

  // Reset values.
  localparam logic [OFFSET_W-1:0] RST_OFFSET_MV      = 8'd25;
  localparam logic [MV_W-1:0]     RST_CRITICAL_MV    = 15'd3200;
  localparam logic [MV_W-1:0]     RST_MID_MV         = 15'd3400;
  localparam logic [MV_W-1:0]     RST_FULL_MV        = 15'd3800;
  localparam logic [MV_W-1:0]     RST_SHUTDOWN_MV    = 15'd3100;
  localparam logic [TIMER_W-1:0]  RST_SHUTDOWN_HOLD  = 16'd5000;
  localparam logic [TIMER_W-1:0]  RST_BLINK_HALF     = 16'd500;
  localparam logic [TIMER_W-1:0]  RST_READ_PERIOD    = 16'd5000;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset_mv;
    logic [MV_W-1:0]     critical_mv;
    logic [MV_W-1:0]     mid_mv;
    logic [MV_W-1:0]     full_mv;
    logic [MV_W-1:0]     shutdown_mv;
    logic [TIMER_W-1:0]  shutdown_hold_ms;
    logic [TIMER_W-1:0]  blink_half_ms;
    logic [TIMER_W-1:0]  read_period_ms;
  } cfg_t;

  function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] t);
    return (t == {TIMER_W{1'b1}}) ? t : t + TIMER_W'(1);
  endfunction

endpackage

>>> rtl/battery_level_monitor_unit.sv
// Channel  | handshake             | payload
// ---------+-----------------------+------------------------------------------------
// in       | in_valid / in_ready   | action, sample_mv
// out      | out_valid / out_ready | sample_request, battery_mv, led_one, led_two,
//          |                       | led_three, critical, shutdown
// cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item per cycle while the output is not stalled: an accepted item updates all
// state in the same edge and its result lands in the output register.
// The only path limiting rate is the output register: in_ready is high while
// that register is empty or being drained, so a stalled output holds new items.
// cfg_ready is always high; writes take effect in the cycle after they are accepted.
// rst (synchronous) restores default registers, clears timers and the shutdown
// latch, and preloads the read timer so the first tick raises sample_request.
module battery_level_monitor_unit (
  input  logic                            clk,
  input  logic                            rst,
  // input items
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            action,
  input  logic [blm_pkg::SAMPLE_W-1:0]    sample_mv,
  // result items
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            sample_request,
  output logic [blm_pkg::MV_W-1:0]        battery_mv,
  output logic                            led_one,
  output logic                            led_two,
  output logic                            led_three,
  output logic                            critical,
  output logic                            shutdown,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [blm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [blm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  blm_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  blm_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // State
  logic [blm_pkg::SUM_W-1:0]   sample_sum,    sample_sum_next;
  logic [blm_pkg::CNT_W-1:0]   sample_count,  sample_count_next;
  logic [blm_pkg::MV_W-1:0]    voltage_reg,   voltage_reg_next;
  logic [blm_pkg::TIMER_W-1:0] read_timer,    read_timer_next;
  logic [blm_pkg::TIMER_W-1:0] low_timer,     low_timer_next;
  logic [blm_pkg::TIMER_W-1:0] blink_timer,   blink_timer_next;
  logic                        blink_phase,   blink_phase_next;
  logic                        shutdown_flag, shutdown_flag_next;
  logic                        request;

  // Sample path helpers
  logic [blm_pkg::SUM_W-1:0]  sum_add;
  logic [blm_pkg::CNT_W-1:0]  cnt_inc;
  logic [blm_pkg::PROD_W-1:0] sum_x11;
  logic [blm_pkg::PROD_W-1:0] avg_scaled;
  // Tick path helpers
  logic [blm_pkg::TIMER_W-1:0] rt_inc, lt_inc, bt_inc;
  logic                        crit_next;

  logic in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign sum_add = sample_sum + blm_pkg::SUM_W'(sample_mv) + blm_pkg::SUM_W'(cfg.offset_mv);
  assign cnt_inc = sample_count + blm_pkg::CNT_W'(1);
  // times 11 as shifts and adds, then divide by 2N (a shift for power-of-two N)
  assign sum_x11 = (blm_pkg::PROD_W'(sum_add) << 3) + (blm_pkg::PROD_W'(sum_add) << 1)
                 + blm_pkg::PROD_W'(sum_add);
  assign avg_scaled = blm_pkg::PROD_W'(sum_x11 / blm_pkg::AVG_DIV);

  assign rt_inc = blm_pkg::sat_inc(read_timer);
  assign lt_inc = blm_pkg::sat_inc(low_timer);
  assign bt_inc = blm_pkg::sat_inc(blink_timer);

  always_comb begin
    sample_sum_next    = sample_sum;
    sample_count_next  = sample_count;
    voltage_reg_next   = voltage_reg;
    read_timer_next    = read_timer;
    low_timer_next     = low_timer;
    blink_timer_next   = blink_timer;
    blink_phase_next   = blink_phase;
    shutdown_flag_next = shutdown_flag;
    request            = 1'b0;

    if (action) begin
      // ADC sample: accumulate, close the group on the last one
      sample_sum_next   = sum_add;
      sample_count_next = cnt_inc;
      if (cnt_inc >= blm_pkg::CNT_W'(blm_pkg::SAMPLES_PER_READ)) begin
        voltage_reg_next  = avg_scaled[blm_pkg::MV_W-1:0];
        sample_sum_next   = '0;
        sample_count_next = '0;
      end
    end else begin
      // Tick: read timer; a request drops any partial group
      read_timer_next = rt_inc;
      if (rt_inc >= cfg.read_period_ms) begin
        request           = 1'b1;
        read_timer_next   = '0;
        sample_sum_next   = '0;
        sample_count_next = '0;
      end

      // Shutdown hold, only with a plausible reading
      if (voltage_reg >= blm_pkg::VALID_MIN_MV) begin
        if (voltage_reg >= cfg.shutdown_mv) begin
          low_timer_next = '0;
        end else begin
          low_timer_next = lt_inc;
          if (lt_inc >= cfg.shutdown_hold_ms) begin
            shutdown_flag_next = 1'b1;
          end
        end
      end

      // Blink of LED one while critical
      blink_timer_next = bt_inc;
      if (voltage_reg < cfg.critical_mv) begin
        if (bt_inc >= cfg.blink_half_ms) begin
          blink_phase_next = !blink_phase;
          blink_timer_next = '0;
        end
      end else begin
        blink_phase_next = 1'b1;
      end
    end
  end

  assign crit_next = voltage_reg_next < cfg.critical_mv;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum    <= '0;
      sample_count  <= '0;
      voltage_reg   <= '0;
      read_timer    <= blm_pkg::RST_READ_PERIOD;
      low_timer     <= '0;
      blink_timer   <= '0;
      blink_phase   <= 1'b1;
      shutdown_flag <= 1'b0;
    end else if (in_fire) begin
      sample_sum    <= sample_sum_next;
      sample_count  <= sample_count_next;
      voltage_reg   <= voltage_reg_next;
      read_timer    <= read_timer_next;
      low_timer     <= low_timer_next;
      blink_timer   <= blink_timer_next;
      blink_phase   <= blink_phase_next;
      shutdown_flag <= shutdown_flag_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_request <= request;
      battery_mv     <= voltage_reg_next;
      critical       <= crit_next;
      shutdown       <= shutdown_flag_next;
      // shutdown latch blanks the whole bar
      led_one   <= !shutdown_flag_next && (voltage_reg_next != '0)
                   && (!crit_next || blink_phase_next);
      led_two   <= !shutdown_flag_next && (voltage_reg_next >= cfg.mid_mv);
      led_three <= !shutdown_flag_next && (voltage_reg_next >= cfg.full_mv);
    end
  end

endmodule

>>> rtl/blm_cfg.sv
module blm_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [blm_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [blm_pkg::CFG_DATA_W-1:0]  wr_data,
  output blm_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_mv        <= blm_pkg::RST_OFFSET_MV;
      cfg.critical_mv      <= blm_pkg::RST_CRITICAL_MV;
      cfg.mid_mv           <= blm_pkg::RST_MID_MV;
      cfg.full_mv          <= blm_pkg::RST_FULL_MV;
      cfg.shutdown_mv      <= blm_pkg::RST_SHUTDOWN_MV;
      cfg.shutdown_hold_ms <= blm_pkg::RST_SHUTDOWN_HOLD;
      cfg.blink_half_ms    <= blm_pkg::RST_BLINK_HALF;
      cfg.read_period_ms   <= blm_pkg::RST_READ_PERIOD;
    end else if (wr_en) begin
      case (wr_index)
        blm_pkg::REG_OFFSET:        cfg.offset_mv        <= wr_data[blm_pkg::OFFSET_W-1:0];
        blm_pkg::REG_CRITICAL:      cfg.critical_mv      <= wr_data[blm_pkg::MV_W-1:0];
        blm_pkg::REG_MID:           cfg.mid_mv           <= wr_data[blm_pkg::MV_W-1:0];
        blm_pkg::REG_FULL:          cfg.full_mv          <= wr_data[blm_pkg::MV_W-1:0];
        blm_pkg::REG_SHUTDOWN:      cfg.shutdown_mv      <= wr_data[blm_pkg::MV_W-1:0];
        blm_pkg::REG_SHUTDOWN_HOLD: cfg.shutdown_hold_ms <= wr_data;
        blm_pkg::REG_BLINK_HALF:    cfg.blink_half_ms    <= wr_data;
        blm_pkg::REG_READ_PERIOD:   cfg.read_period_ms   <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/blm_checker.sv
module blm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [blm_pkg::MV_W-1:0]        battery_mv,
  input logic                            led_one,
  input logic                            led_two,
  input logic                            led_three,
  input logic                            shutdown
);

  logic sd_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      sd_seen <= 1'b0;
    end else if (out_valid && out_ready && shutdown) begin
      sd_seen <= 1'b1;
    end
  end

  // Shutdown never releases without reset.
  a_sd_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && sd_seen |-> shutdown)
    else $error("shutdown released");

  // Latched shutdown blanks the bar.
  a_sd_dark: assert property (@(posedge clk) disable iff (rst)
    out_valid && shutdown |-> !led_one && !led_two && !led_three)
    else $error("LED on during shutdown");

  // LED one stays off with no reading.
  a_led1_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && led_one |-> battery_mv != '0)
    else $error("LED one on at zero voltage");

  // An empty output stage always takes an item.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(battery_mv) && $stable(shutdown))
    else $error("stalled result changed");

endmodule

bind battery_level_monitor_unit blm_checker u_blm_checker (.*);

>>> tb/blm_bar_checker.sv
`timescale 1ns / 1ps

module blm_bar_checker
  import blm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  action,
  input  logic [SAMPLE_W-1:0]   sample_mv,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  sample_request,
  input  logic [MV_W-1:0]       battery_mv,
  input  logic                  led_one,
  input  logic                  led_two,
  input  logic                  led_three,
  input  logic                  critical,
  input  logic                  shutdown,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic            request;
    logic [MV_W-1:0] mv;
    logic            led1;
    logic            led2;
    logic            led3;
    logic            crit;
    logic            shut;
  } reading_t;

  reading_t           expected_readings[$];
  cfg_t               regs;
  logic [SUM_W-1:0]   group_sum;
  int unsigned        group_len;
  logic [MV_W-1:0]    volts;
  logic [TIMER_W-1:0] read_tmr;
  logic [TIMER_W-1:0] low_tmr;
  logic [TIMER_W-1:0] blink_tmr;
  logic               blink_on;
  logic               latched;
  int                 errors;
  reading_t           got;
  reading_t           want;

  function automatic logic [TIMER_W-1:0] bump(input logic [TIMER_W-1:0] t);
    return (&t) ? t : t + 1'b1;
  endfunction

  // Advances the monitor state by one item and returns the bar it shows.
  function automatic reading_t step_monitor(input logic act,
                                            input logic [SAMPLE_W-1:0] mv);
    reading_t    r;
    logic        req;
    logic        crit;
    int unsigned scaled;
    req = 1'b0;
    if (act) begin
      group_sum = group_sum + SUM_W'(mv) + SUM_W'(regs.offset_mv);
      group_len++;
      if (group_len >= SAMPLES_PER_READ) begin
        scaled    = (int'(group_sum) * 11) / (2 * SAMPLES_PER_READ);
        volts     = scaled[MV_W-1:0];
        group_sum = '0;
        group_len = 0;
      end
    end else begin
      read_tmr = bump(read_tmr);
      if (read_tmr >= regs.read_period_ms) begin
        req       = 1'b1;
        read_tmr  = '0;
        group_sum = '0;
        group_len = 0;
      end
      // hold timer only runs on a plausible reading
      if (volts >= VALID_MIN_MV) begin
        if (volts >= regs.shutdown_mv) begin
          low_tmr = '0;
        end else begin
          low_tmr = bump(low_tmr);
          if (low_tmr >= regs.shutdown_hold_ms) latched = 1'b1;
        end
      end
      blink_tmr = bump(blink_tmr);
      if (volts < regs.critical_mv) begin
        if (blink_tmr >= regs.blink_half_ms) begin
          blink_on  = ~blink_on;
          blink_tmr = '0;
        end
      end else begin
        blink_on = 1'b1;
      end
    end
    crit      = volts < regs.critical_mv;
    r.request = req;
    r.mv      = volts;
    r.led1    = !latched && (volts != '0) && (!crit || blink_on);
    r.led2    = !latched && (volts >= regs.mid_mv);
    r.led3    = !latched && (volts >= regs.full_mv);
    r.crit    = crit;
    r.shut    = latched;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      regs.offset_mv        = RST_OFFSET_MV;
      regs.critical_mv      = RST_CRITICAL_MV;
      regs.mid_mv           = RST_MID_MV;
      regs.full_mv          = RST_FULL_MV;
      regs.shutdown_mv      = RST_SHUTDOWN_MV;
      regs.shutdown_hold_ms = RST_SHUTDOWN_HOLD;
      regs.blink_half_ms    = RST_BLINK_HALF;
      regs.read_period_ms   = RST_READ_PERIOD;
      group_sum = '0;
      group_len = 0;
      volts     = '0;
      read_tmr  = RST_READ_PERIOD;
      low_tmr   = '0;
      blink_tmr = '0;
      blink_on  = 1'b1;
      latched   = 1'b0;
      errors    = 0;
      expected_readings.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {sample_request, battery_mv, led_one, led_two, led_three, critical, shutdown};
        if (expected_readings.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result req=%0b mv=%0d leds=%0b%0b%0b crit=%0b shut=%0b",
                     $realtime, got.request, got.mv, got.led1, got.led2, got.led3,
                     got.crit, got.shut);
        end else begin
          want = expected_readings.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch exp req=%0b mv=%0d leds=%0b%0b%0b crit=%0b shut=%0b",
                       $realtime, want.request, want.mv, want.led1, want.led2, want.led3,
                       want.crit, want.shut);
              $display("%0t:          got req=%0b mv=%0d leds=%0b%0b%0b crit=%0b shut=%0b",
                       $realtime, got.request, got.mv, got.led1, got.led2, got.led3,
                       got.crit, got.shut);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OFFSET:        regs.offset_mv        = cfg_data[OFFSET_W-1:0];
          REG_CRITICAL:      regs.critical_mv      = cfg_data[MV_W-1:0];
          REG_MID:           regs.mid_mv           = cfg_data[MV_W-1:0];
          REG_FULL:          regs.full_mv          = cfg_data[MV_W-1:0];
          REG_SHUTDOWN:      regs.shutdown_mv      = cfg_data[MV_W-1:0];
          REG_SHUTDOWN_HOLD: regs.shutdown_hold_ms = cfg_data[TIMER_W-1:0];
          REG_BLINK_HALF:    regs.blink_half_ms    = cfg_data[TIMER_W-1:0];
          REG_READ_PERIOD:   regs.read_period_ms   = cfg_data[TIMER_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_readings.push_back(step_monitor(action, sample_mv));
    end
    fail_count <= errors;
    pending    <= expected_readings.size();
  end

endmodule

>>> tb/tb_battery_level_monitor_unit.sv
`timescale 1ns / 1ps

module tb_battery_level_monitor_unit;
  import blm_pkg::*;

  // generous ceiling, far above what a full run with random stalls needs
  localparam int LIMIT = 1000000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic                  action;
  logic [SAMPLE_W-1:0]   sample_mv;
  logic                  out_valid;
  logic                  out_ready;
  logic                  sample_request;
  logic [MV_W-1:0]       battery_mv;
  logic                  led_one;
  logic                  led_two;
  logic                  led_three;
  logic                  critical;
  logic                  shutdown;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int   fail_count;
  int   pending;
  int   cycles;
  logic steady;        // when set, neither side idles
  cfg_t setting;

  battery_level_monitor_unit uut (
    .clk, .rst,
    .in_valid, .in_ready, .action, .sample_mv,
    .out_valid, .out_ready, .sample_request, .battery_mv,
    .led_one, .led_two, .led_three, .critical, .shutdown,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  blm_bar_checker u_checker (
    .clk, .rst,
    .in_valid, .in_ready, .action, .sample_mv,
    .out_valid, .out_ready, .sample_request, .battery_mv,
    .led_one, .led_two, .led_three, .critical, .shutdown,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: stalls about a quarter of the time unless steady
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 26);
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // One item: optional idle cycles first, then valid held until taken.
  // Valid is left high afterwards so back-to-back items never drop it.
  task automatic send_item(input logic act, input logic [SAMPLE_W-1:0] mv);
    while (!steady && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    sample_mv <= mv;
    do @(posedge clk); while (!in_ready);
  endtask

  // sender pauses until every result is back
  task automatic wait_results_in();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes all eight registers while idle. With noisy set, bits above each
  // register's width carry junk that the block must drop.
  task automatic load_regs(input cfg_t c, input logic noisy);
    wait_results_in();
    repeat (2) @(posedge clk);
    write_reg(REG_OFFSET,        {noisy ? 8'($urandom) : 8'h00, c.offset_mv});
    write_reg(REG_CRITICAL,      {noisy & 1'($urandom), c.critical_mv});
    write_reg(REG_MID,           {noisy & 1'($urandom), c.mid_mv});
    write_reg(REG_FULL,          {noisy & 1'($urandom), c.full_mv});
    write_reg(REG_SHUTDOWN,      {noisy, c.shutdown_mv});
    write_reg(REG_SHUTDOWN_HOLD, c.shutdown_hold_ms);
    write_reg(REG_BLINK_HALF,    c.blink_half_ms);
    write_reg(REG_READ_PERIOD,   c.read_period_ms);
    cfg_valid <= 1'b0;
  endtask

  // Random thresholds; shutdown_mv of zero keeps the latch away until the
  // last phase since only reset clears it.
  function automatic cfg_t random_regs();
    cfg_t c;
    c.offset_mv        = OFFSET_W'($urandom_range(0, 255));
    c.critical_mv      = MV_W'($urandom_range(0, 22660));
    c.mid_mv           = MV_W'($urandom_range(0, 22660));
    c.full_mv          = MV_W'($urandom_range(0, 22660));
    c.shutdown_mv      = '0;
    c.shutdown_hold_ms = TIMER_W'($urandom_range(0, 65535));
    c.blink_half_ms    = TIMER_W'($urandom_range(1, 20));
    c.read_period_ms   = TIMER_W'($urandom_range(40, 400));
    return c;
  endfunction

  // A full group near one level: the samples jitter a little around base.
  task automatic send_group(input int base);
    int v;
    int n;
    for (n = 0; n < SAMPLES_PER_READ; n++) begin
      v = base + int'($urandom_range(0, 64)) - 32;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      send_item(1'b1, SAMPLE_W'(v));
    end
  endtask

  // Mostly complete sample groups followed by a few ticks; the rest is
  // loose items and groups cut short by a tick.
  task automatic random_items(input int count);
    int sent;
    int n;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 2) wait_results_in();
      if ($urandom_range(0, 99) < 75) begin
        send_group($urandom_range(0, 4095));
        n = $urandom_range(1, 12);
        repeat (n) send_item(1'b0, SAMPLE_W'($urandom));
        sent += SAMPLES_PER_READ + n;
      end else if ($urandom_range(0, 1) == 0) begin
        send_item(1'($urandom), SAMPLE_W'($urandom));
        sent++;
      end else begin
        n = $urandom_range(1, SAMPLES_PER_READ - 1);
        repeat (n) send_item(1'b1, SAMPLE_W'($urandom));
        send_item(1'b0, SAMPLE_W'($urandom));
        sent += n + 1;
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    action    = 1'b0;
    sample_mv = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_OFFSET;
    cfg_data  = '0;
    steady    = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // --- directed, reset settings ---
    // first tick: priming request, zero voltage is critical but LED one dark
    send_item(1'b0, '0);
    // full-scale group: every sample at 4095, the top of the sample range
    repeat (SAMPLES_PER_READ) send_item(1'b1, 12'hFFF);
    send_item(1'b0, 12'hFFF);
    // partial group, alternating bit patterns, ticks
    send_item(1'b1, 12'h000);
    send_item(1'b1, 12'hAAA);
    send_item(1'b1, 12'h555);
    send_item(1'b0, 12'h000);
    send_item(1'b0, 12'h555);

    // --- random settings ---
    load_regs(random_regs(), 1'b0);
    random_items(120);

    // --- extremes: critical below 22660 mV, zero blink half and zero read period ---
    setting.offset_mv        = 8'd255;
    setting.critical_mv      = MV_W'(22660);
    setting.mid_mv           = '0;
    setting.full_mv          = MV_W'(22660);
    setting.shutdown_mv      = '0;
    setting.shutdown_hold_ms = 16'hFFFF;
    setting.blink_half_ms    = '0;
    setting.read_period_ms   = '0;
    load_regs(setting, 1'b0);
    random_items(80);

    // --- extremes the other way ---
    setting.offset_mv        = '0;
    setting.critical_mv      = '0;
    setting.mid_mv           = MV_W'(22660);
    setting.full_mv          = '0;
    setting.shutdown_mv      = '0;
    setting.shutdown_hold_ms = '0;
    setting.blink_half_ms    = 16'hFFFF;
    setting.read_period_ms   = 16'hFFFF;
    load_regs(setting, 1'b0);
    random_items(80);

    // --- junk in the unused data bits, no idling on either side ---
    steady <= 1'b1;
    load_regs(random_regs(), 1'b1);
    random_items(100);

    // --- longest read period and no critical level: only ticks after
    // one group, the blink timer keeps counting ---
    setting = random_regs();
    setting.critical_mv    = '0;
    setting.read_period_ms = 16'hFFFF;
    load_regs(setting, 1'b0);
    send_group(2000);
    repeat (20) send_item(1'b0, SAMPLE_W'($urandom));
    steady <= 1'b0;

    // critical again with the longest half period: LED one holds its phase
    setting.critical_mv    = MV_W'(22660);
    setting.blink_half_ms  = 16'hFFFF;
    setting.read_period_ms = 16'd1000;
    load_regs(setting, 1'b0);
    repeat (5) send_item(1'b0, SAMPLE_W'($urandom));
    random_items(60);

    // --- shutdown latch: a plausible reading below 22660 mV counts as low ---
    setting = random_regs();
    setting.shutdown_mv      = MV_W'(22660);
    setting.shutdown_hold_ms = TIMER_W'($urandom_range(1, 40));
    setting.read_period_ms   = TIMER_W'($urandom_range(200, 400));
    load_regs(setting, 1'b0);
    random_items(140);

    wait_results_in();
    repeat (5) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
